// ===== hw/rtl/clcd_pkg.sv =====
// Shared types, command codes and cursor helper functions for the character LCD sequencer.
`default_nettype none

package clcd_pkg;

   localparam logic [3:0] OP_INIT    = 4'd0;
   localparam logic [3:0] OP_HOME    = 4'd1;
   localparam logic [3:0] OP_CLEAR   = 4'd2;
   localparam logic [3:0] OP_WRITE   = 4'd3;
   localparam logic [3:0] OP_GOTO    = 4'd4;
   localparam logic [3:0] OP_PUTC    = 4'd5;
   localparam logic [3:0] OP_PUTHEX  = 4'd6;
   localparam logic [3:0] OP_SET     = 4'd7;
   localparam logic [3:0] OP_CRLF    = 4'd8;
   localparam logic [3:0] OP_SAVE    = 4'd9;
   localparam logic [3:0] OP_RESTORE = 4'd10;

   localparam int MAX_BYTES = 4;

   localparam logic [6:0] ROW1_START = 7'd20;
   localparam logic [6:0] ROW2_START = 7'd40;
   localparam logic [6:0] ROW3_START = 7'd60;
   localparam logic [6:0] POS_END    = 7'd80;

   localparam logic [7:0] CMD_FUNC_SET = 8'h28;
   localparam logic [7:0] CMD_DISP_OFF = 8'h08;
   localparam logic [7:0] CMD_CLEAR    = 8'h01;
   localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
   localparam logic [7:0] CMD_HOME     = 8'h02;
   localparam logic [7:0] LINE0_ADDR   = 8'h80;
   localparam logic [7:0] LINE1_ADDR   = 8'hC0;
   localparam logic [7:0] LINE2_ADDR   = 8'h94;
   localparam logic [7:0] LINE3_ADDR   = 8'hD4;

   localparam logic [3:0] NIB_WAKE = 4'h3;
   localparam logic [3:0] NIB_4BIT = 4'h2;

   localparam logic RS_CMD  = 1'b0;
   localparam logic RS_DATA = 1'b1;

   typedef struct packed {
      logic       rs;
      logic [7:0] data;
   } clcd_byte_type;

   typedef struct packed {
      logic                                wake;
      logic [2:0]                          count;
      clcd_byte_type [MAX_BYTES-1:0]       bytes;
   } clcd_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } clcd_qstat_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] cmd;
   } clcd_line_type;

   function automatic clcd_line_type line_start(input logic [6:0] p);
      clcd_line_type r;
      r.hit = 1'b1;
      r.cmd = LINE0_ADDR;
      if (p == 7'd0 || p == POS_END) begin
         r.cmd = LINE0_ADDR;
      end else if (p == ROW1_START) begin
         r.cmd = LINE1_ADDR;
      end else if (p == ROW2_START) begin
         r.cmd = LINE2_ADDR;
      end else if (p == ROW3_START) begin
         r.cmd = LINE3_ADDR;
      end else begin
         r.hit = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [6:0] next_pos(input logic [6:0] p);
      logic [6:0] n;
      n = p + 7'd1;
      if (n == POS_END) begin
         n = 7'd0;
      end
      return n;
   endfunction

   function automatic logic [7:0] line_addr(input logic [6:0] p);
      logic [7:0] a;
      a = {1'b0, p};
      if (p < ROW1_START) begin
         a = a;
      end else if (p < ROW2_START) begin
         a = a + 8'h2C;
      end else if (p < ROW3_START) begin
         a = a - 8'd20;
      end else begin
         a = a + 8'h18;
      end
      return a | 8'h80;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] d);
      return (d < 4'd10) ? ({4'h0, d} + 8'h30) : ({4'h0, d} + 8'h37);
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/clcd_front.sv =====
// Front end: accepts commands, tracks the cursor and builds the byte list of each command.
`default_nettype none

module clcd_front
   import clcd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire logic [3:0]     req_operation,
   input  wire logic [7:0]     req_char_code,
   input  wire logic [1:0]     req_row,
   input  wire logic [4:0]     req_col,
   input  wire logic [7:0]     req_command_byte,
   input  wire clcd_qstat_type q_stat,
   output logic                enq,
   output clcd_job_type        job
);

   logic [6:0]    cursor_ff, cursor_in;
   logic [6:0]    saved_ff, saved_in;
   logic          accept;
   logic [2:0]    n;
   logic [6:0]    p;
   clcd_line_type ln;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !q_stat.full;
   assign enq       = accept && (job.wake || job.count != 3'd0);

   always_comb begin
      job       = '0;
      n         = 3'd0;
      p         = cursor_ff;
      ln        = '0;
      cursor_in = cursor_ff;
      saved_in  = saved_ff;
      unique case (req_operation)
         OP_INIT: begin
            job.wake     = 1'b1;
            job.bytes[0] = {RS_CMD, CMD_FUNC_SET};
            job.bytes[1] = {RS_CMD, CMD_DISP_OFF};
            job.bytes[2] = {RS_CMD, CMD_CLEAR};
            job.bytes[3] = {RS_CMD, CMD_DISP_ON};
            n            = 3'd4;
            cursor_in    = 7'd0;
         end
         OP_HOME: begin
            job.bytes[0] = {RS_CMD, CMD_HOME};
            n            = 3'd1;
            cursor_in    = 7'd0;
         end
         OP_CLEAR: begin
            job.bytes[0] = {RS_CMD, CMD_CLEAR};
            n            = 3'd1;
            cursor_in    = 7'd0;
         end
         OP_WRITE: begin
            job.bytes[0] = {RS_DATA, req_char_code};
            n            = 3'd1;
         end
         OP_GOTO: begin
            p         = 7'(req_row) * 7'd20 + 7'(req_col);
            cursor_in = p;
            if (p < POS_END) begin
               job.bytes[0] = {RS_CMD, line_addr(p)};
               n            = 3'd1;
            end
         end
         OP_PUTC: begin
            ln = line_start(cursor_ff);
            if (ln.hit) begin
               job.bytes[n[1:0]] = {RS_CMD, ln.cmd};
               n = n + 3'd1;
            end
            job.bytes[n[1:0]] = {RS_DATA, req_char_code};
            n         = n + 3'd1;
            cursor_in = next_pos(cursor_ff);
         end
         OP_PUTHEX: begin
            ln = line_start(p);
            if (ln.hit) begin
               job.bytes[n[1:0]] = {RS_CMD, ln.cmd};
               n = n + 3'd1;
            end
            job.bytes[n[1:0]] = {RS_DATA, hex_digit(req_char_code[7:4])};
            n  = n + 3'd1;
            p  = next_pos(p);
            ln = line_start(p);
            if (ln.hit) begin
               job.bytes[n[1:0]] = {RS_CMD, ln.cmd};
               n = n + 3'd1;
            end
            job.bytes[n[1:0]] = {RS_DATA, hex_digit(req_char_code[3:0])};
            n         = n + 3'd1;
            cursor_in = next_pos(p);
         end
         OP_SET: begin
            job.bytes[0] = {RS_CMD, req_command_byte};
            n            = 3'd1;
         end
         OP_CRLF: begin
            if (cursor_ff < ROW1_START) begin
               p = ROW1_START;
            end else if (cursor_ff < ROW2_START) begin
               p = ROW2_START;
            end else if (cursor_ff < ROW3_START) begin
               p = ROW3_START;
            end else begin
               p = 7'd0;
            end
            cursor_in    = p;
            job.bytes[0] = {RS_CMD, line_addr(p)};
            n            = 3'd1;
         end
         OP_SAVE: begin
            saved_in = cursor_ff;
         end
         OP_RESTORE: begin
            cursor_in = saved_ff;
            if (saved_ff < POS_END) begin
               job.bytes[0] = {RS_CMD, line_addr(saved_ff)};
               n            = 3'd1;
            end
         end
         default: begin
            n = 3'd0;
         end
      endcase
      job.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= 7'd0;
         saved_ff  <= 7'd0;
      end else if (accept) begin
         cursor_ff <= cursor_in;
         saved_ff  <= saved_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/clcd_queue.sv =====
// Short job queue between the front end and the nibble back end.
`default_nettype none

module clcd_queue
   import clcd_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          enq,
   input  wire clcd_job_type  wr_job,
   input  wire logic          deq,
   output clcd_job_type       rd_job,
   output clcd_qstat_type     stat
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   clcd_job_type    entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign rd_job     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (enq) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (enq && !deq) begin
         count_in = count_ff + 1'b1;
      end else if (deq && !enq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         entry_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/clcd_back.sv =====
// Back end: walks the head job and sends one nibble transfer per cycle while rsp_stall is low.
`default_nettype none

module clcd_back
   import clcd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire clcd_job_type   head,
   input  wire clcd_qstat_type q_stat,
   output logic                deq,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output logic                rsp_register_select,
   output logic [3:0]          rsp_nibble,
   output logic                rsp_last
);

   logic [3:0]    idx_ff, idx_in;
   logic          rsp_valid_ff;
   logic          rs_ff;
   logic [3:0]    nib_ff;
   logic          last_ff;
   logic [3:0]    offset;
   logic [3:0]    total;
   logic [2:0]    j;
   clcd_byte_type cur;
   logic          rs_sel;
   logic [3:0]    nib_sel;
   logic          is_last;
   logic          advance;
   logic          load;

   assign offset  = head.wake ? 4'd4 : 4'd0;
   assign total   = {head.count, 1'b0} + offset;
   assign j       = 3'(idx_ff - offset);
   assign cur     = head.bytes[j[2:1]];
   assign is_last = (idx_ff == total - 4'd1);
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign load    = advance && !q_stat.empty;
   assign deq     = load && is_last;
   assign idx_in  = is_last ? 4'd0 : idx_ff + 4'd1;

   always_comb begin
      if (head.wake && idx_ff < 4'd4) begin
         rs_sel  = RS_CMD;
         nib_sel = (idx_ff == 4'd3) ? NIB_4BIT : NIB_WAKE;
      end else begin
         rs_sel  = cur.rs;
         nib_sel = j[0] ? cur.data[3:0] : cur.data[7:4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 4'd0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= !q_stat.empty;
         end
         if (load) begin
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rs_ff   <= rs_sel;
         nib_ff  <= nib_sel;
         last_ff <= is_last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_register_select = rs_ff;
   assign rsp_nibble          = nib_ff;
   assign rsp_last            = last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/char_lcd_command_sequencer_core.sv =====
// Top level of the character LCD command sequencer for a 4x20 panel on a 4-bit bus.
`default_nettype none

// Each accepted command is turned into a list of nibble writes, high nibble first, with a
// register-select bit; last marks the final nibble of a command. The front end takes one
// command per cycle as long as the job queue (QUEUE_DEPTH entries) has room, and commands
// that produce no output (save, out-of-panel goto or restore, unused codes) are not queued.
// The back end sends one nibble per cycle while rsp_stall is low. A command has 2 nibbles
// for home, clear, raw write, set, goto, carriage return and restore, 2 to 4 for put
// character, 4 to 6 for put hex and 12 for init.
module char_lcd_command_sequencer_core
   import clcd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [3:0] req_operation,
   input  wire logic [7:0] req_char_code,
   input  wire logic [1:0] req_row,
   input  wire logic [4:0] req_col,
   input  wire logic [7:0] req_command_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_register_select,
   output logic [3:0]      rsp_nibble,
   output logic            rsp_last
);

   clcd_qstat_type q_stat;
   clcd_job_type   wr_job;
   clcd_job_type   head;
   logic           enq;
   logic           deq;

   clcd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_char_code    (req_char_code),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_command_byte (req_command_byte),
      .q_stat           (q_stat),
      .enq              (enq),
      .job              (wr_job)
   );

   clcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .enq    (enq),
      .wr_job (wr_job),
      .deq    (deq),
      .rd_job (head),
      .stat   (q_stat)
   );

   clcd_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .q_stat              (q_stat),
      .deq                 (deq),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_register_select (rsp_register_select),
      .rsp_nibble          (rsp_nibble),
      .rsp_last            (rsp_last)
   );

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

   a_job_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> rsp_valid)
      else $error("gap inside a command's nibble sequence");

   a_queue_drains: assert property (@(posedge clock) disable iff (reset)
      (!q_stat.empty && !rsp_valid) |=> rsp_valid)
      else $error("pending job not sent to the output register");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      deq |-> !q_stat.empty)
      else $error("job queue popped while empty");

endmodule

`default_nettype wire
